[rtl/core/sbpr_pkg.sv]
package sbpr_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] CHECK_VALUE = 8'hFF;
    localparam logic [7:0] DEVICE_ID_RESET = 8'h01;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4
    } parse_phase_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SEND = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] frame_length;
        logic [7:0] count;
    } frame_desc_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } store_wr_t;

endpackage

[rtl/core/servo_bus_packet_receiver_unit.sv]
// A frame's results leave only after its final byte is accepted. Throughput: one
// received byte per cycle; results leave at one per cycle while the sink is ready,
// from the single read port of the body store. Body bytes of the next frame wait
// while the store still holds a frame being sent; its header bytes are taken meanwhile.
// Reset: parser returns to header hunt, device ID becomes 1, store contents undefined.
module servo_bus_packet_receiver_unit
    import sbpr_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // node_id, frame_length, byte_index, body_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic        back_busy;
    logic        push;
    logic        pop;
    logic        desc_valid;
    frame_desc_t push_desc;
    frame_desc_t head_desc;
    store_wr_t   store_wr;

    sbpr_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .back_busy (back_busy),
        .push      (push),
        .push_desc (push_desc),
        .store_wr  (store_wr)
    );

    sbpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .not_empty (desc_valid),
        .head      (head_desc)
    );

    sbpr_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_wr   (store_wr),
        .desc_valid (desc_valid),
        .desc       (head_desc),
        .pop        (pop),
        .busy       (back_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/core/sbpr_front.sv]
module sbpr_front
    import sbpr_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        back_busy,
    output logic        push,
    output frame_desc_t push_desc,
    output store_wr_t   store_wr
);

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   device_id_reg, device_id_next;
    logic [7:0]   frame_id_reg, frame_id_next;
    logic [7:0]   length_reg, length_next;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   sum_reg, sum_next;
    logic         take;
    logic [7:0]   count_inc;
    logic [7:0]   sum_add;
    logic         frame_end;
    logic         frame_good;
    logic         in_store;

    assign count_inc  = count_reg + 8'd1;
    assign sum_add    = sum_reg + s_tdata;
    assign frame_end  = (count_inc >= length_reg);
    assign in_store   = ({1'b0, count_reg} < 9'(STORE_DEPTH));
    assign frame_good = (sum_add == CHECK_VALUE) && ({1'b0, count_inc} < 9'(STORE_DEPTH));

    assign cfg_ready = 1'b1;
    assign device_id_next = (cfg_valid && cfg_ready) ? cfg_data : device_id_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            unique case (phase_reg)
                PH_HDR1: phase_next = (s_tdata == SYNC_BYTE) ? PH_HDR2 : PH_HDR1;
                PH_HDR2: phase_next = (s_tdata == SYNC_BYTE) ? PH_ID : PH_HDR1;
                PH_ID:   phase_next = (s_tdata == device_id_reg) ? PH_LEN : PH_HDR1;
                PH_LEN:  phase_next = PH_BODY;
                PH_BODY: phase_next = frame_end ? PH_HDR1 : PH_BODY;
                default: phase_next = PH_HDR1;
            endcase
        end
    end

    // outputs and datapath
    always_comb
    begin
        s_tready       = !((phase_reg == PH_BODY) && back_busy);
        take           = s_tvalid && s_tready;
        frame_id_next  = frame_id_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        push           = 1'b0;
        store_wr.en    = 1'b0;
        store_wr.addr  = count_reg;
        store_wr.data  = s_tdata;
        push_desc.node_id      = frame_id_reg;
        push_desc.frame_length = length_reg;
        push_desc.count        = count_inc;
        if (take)
        begin
            unique case (phase_reg)
                PH_ID:
                begin
                    if (s_tdata == device_id_reg)
                    begin
                        frame_id_next = s_tdata;
                        sum_next      = s_tdata;
                    end
                end
                PH_LEN:
                begin
                    length_next = s_tdata;
                    count_next  = 8'd0;
                    sum_next    = sum_add;
                end
                PH_BODY:
                begin
                    store_wr.en = in_store;
                    sum_next    = sum_add;
                    count_next  = count_inc;
                    push        = frame_end && frame_good;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR1;
            device_id_reg <= DEVICE_ID_RESET;
            frame_id_reg  <= 8'd0;
            length_reg    <= 8'd0;
            count_reg     <= 8'd0;
            sum_reg       <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            device_id_reg <= device_id_next;
            frame_id_reg  <= frame_id_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

[rtl/core/sbpr_queue.sv]
module sbpr_queue
    import sbpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_desc,
    input  logic        pop,
    output logic        not_empty,
    output frame_desc_t head
);

    frame_desc_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push;
    logic        do_pop;

    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && (fill_reg != 2'd2);
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/core/sbpr_back.sv]
module sbpr_back
    import sbpr_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  store_wr_t   store_wr,
    input  logic        desc_valid,
    input  frame_desc_t desc,
    output logic        pop,
    output logic        busy,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0]  store_mem [STORE_DEPTH];

    back_state_t state_reg, state_next;
    logic [7:0]  k_reg, k_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  len_reg, len_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  rd_reg;
    logic [4:0]  idx_reg;
    logic        last_reg;
    logic [7:0]  out_id_reg;
    logic [7:0]  out_len_reg;
    logic        issue;
    logic        is_last;

    assign is_last = (k_reg == count_reg - 8'd1);
    assign busy    = (state_reg == BK_SEND) || desc_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: state_next = desc_valid ? BK_SEND : BK_IDLE;
            BK_SEND: state_next = (issue && is_last) ? BK_IDLE : BK_SEND;
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop        = 1'b0;
        issue      = 1'b0;
        k_next     = k_reg;
        count_next = count_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = desc_valid;
                if (desc_valid)
                begin
                    k_next     = 8'd0;
                    count_next = desc.count;
                    id_next    = desc.node_id;
                    len_next   = desc.frame_length;
                end
            end
            BK_SEND:
            begin
                issue  = !out_valid_reg || m_tready;
                k_next = issue ? k_reg + 8'd1 : k_reg;
            end
            default:
            begin
            end
        endcase
        out_valid_next = issue ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
        end
        if (issue)
        begin
            rd_reg      <= store_mem[k_reg[AW-1:0]];
            idx_reg     <= k_reg[4:0];
            last_reg    <= is_last;
            out_id_reg  <= id_reg;
            out_len_reg <= len_reg;
        end
        k_reg     <= k_next;
        count_reg <= count_next;
        id_reg    <= id_next;
        len_reg   <= len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, rd_reg, idx_reg, out_len_reg, out_id_reg};
    assign m_tlast  = last_reg;

endmodule

[rtl/core/sbpr_checker.sv]
module sbpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_ready
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result request changed while stalled");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            !m_tvalid || (m_tdata[20:16] == $past(m_tdata[20:16]) + 5'd1))
        else $error("byte index skipped within a frame");

    a_index_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[20:16] == 5'd0))
        else $error("new frame does not start at index zero");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind servo_bus_packet_receiver_unit sbpr_checker u_sbpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

[tb/sbpr_frame_checker.sv]
`timescale 1ns / 1ps

module sbpr_frame_checker
    import sbpr_pkg::*;
#(
    parameter int STORE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // node_id, frame_length, byte_index, body_byte
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending_beats,
    output int          frames_accepted,
    output int          beats_checked
);

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] frame_length;
        logic [4:0] byte_index;
        logic [7:0] body_byte;
        logic       last_byte;
    } frame_beat_t;

    frame_beat_t  frame_beats_q[$];
    parse_phase_t phase;
    logic [7:0]   device_id;
    logic [7:0]   frame_node;
    logic [7:0]   length_seen;
    logic [7:0]   body_count;
    logic [7:0]   running_sum;
    logic [7:0]   body_mem [STORE_DEPTH];

    task automatic parse_rx_byte(input logic [7:0] c);
        frame_beat_t beat;
        case (phase)
            PH_HDR2:
            begin
                phase = (c == SYNC_BYTE) ? PH_ID : PH_HDR1;
            end
            PH_ID:
            begin
                if (c != device_id)
                begin
                    phase = PH_HDR1;
                end
                else
                begin
                    frame_node  = c;
                    running_sum = c;
                    phase       = PH_LEN;
                end
            end
            PH_LEN:
            begin
                length_seen = c;
                body_count  = 8'd0;
                running_sum = running_sum + c;
                phase       = PH_BODY;
            end
            PH_BODY:
            begin
                if (body_count < STORE_DEPTH)
                    body_mem[body_count] = c;
                running_sum = running_sum + c;
                body_count  = body_count + 8'd1;
                if (body_count >= length_seen)
                begin
                    // accept only a good sum whose body is shorter than STORE_DEPTH
                    if (running_sum == CHECK_VALUE && body_count < STORE_DEPTH)
                    begin
                        for (int k = 0; k < body_count; k++)
                        begin
                            beat.node_id      = frame_node;
                            beat.frame_length = length_seen;
                            beat.byte_index   = 5'(k);
                            beat.body_byte    = body_mem[k];
                            beat.last_byte    = (k == body_count - 1);
                            frame_beats_q.push_back(beat);
                        end
                        frames_accepted++;
                    end
                    phase = PH_HDR1;
                end
            end
            default:
            begin
                phase = (c == SYNC_BYTE) ? PH_HDR2 : PH_HDR1;
            end
        endcase
    endtask

    task automatic check_beat();
        frame_beat_t want;
        frame_beat_t got;
        got = {m_tdata[7:0], m_tdata[15:8], m_tdata[20:16], m_tdata[28:21], m_tlast};
        if (frame_beats_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected result id=%h len=%h idx=%0d byte=%h last=%b",
                         $realtime, got.node_id, got.frame_length, got.byte_index,
                         got.body_byte, got.last_byte);
        end
        else
        begin
            want = frame_beats_q.pop_front();
            beats_checked++;
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"%0t: mismatch exp id=%h len=%h idx=%0d byte=%h last=%b",
                              " got id=%h len=%h idx=%0d byte=%h last=%b"},
                             $realtime, want.node_id, want.frame_length, want.byte_index,
                             want.body_byte, want.last_byte, got.node_id, got.frame_length,
                             got.byte_index, got.body_byte, got.last_byte);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id       = DEVICE_ID_RESET;
            phase           = PH_HDR1;
            frame_node      = 8'd0;
            length_seen     = 8'd0;
            body_count      = 8'd0;
            running_sum     = 8'd0;
            fail_count      = 0;
            pending_beats   = 0;
            frames_accepted = 0;
            beats_checked   = 0;
            frame_beats_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                device_id = cfg_data;
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_beat();
            pending_beats = frame_beats_q.size();
        end
    end

endmodule

[tb/tb_servo_bus_packet_receiver_unit.sv]
`timescale 1ns / 1ps

module tb_servo_bus_packet_receiver_unit;
    import sbpr_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 40;
    localparam int SEGMENTS      = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    int fail_count;
    int pending_beats;
    int frames_accepted;
    int beats_checked;

    logic [7:0] rx_q[$];
    logic [7:0] cur_id;
    bit         source_gaps;
    bit         sink_stalls;
    int         hold_requests;
    int         bytes_sent;
    int         cycle_count;

    servo_bus_packet_receiver_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sbpr_frame_checker i_frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_beats   (pending_beats),
        .frames_accepted (frames_accepted),
        .beats_checked   (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_beats);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result sink: random stall bursts, plus a long hold-off on request
    initial
    begin
        int   burst_left;
        int   hold_left;
        int   holds_served;
        logic ready_next;
        burst_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        m_tready     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                ready_next = 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 8) - 1;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    function automatic void push_frame(input logic [7:0] id, input logic [7:0] len,
                                       input bit with_sync, input bit bad_sum);
        int         n;
        logic [7:0] sum;
        logic [7:0] b;
        n   = (len == 8'd0) ? 1 : int'(len);
        sum = id + len;
        if (with_sync)
        begin
            rx_q.push_back(SYNC_BYTE);
            rx_q.push_back(SYNC_BYTE);
        end
        rx_q.push_back(id);
        rx_q.push_back(len);
        for (int i = 0; i < n - 1; i++)
        begin
            b = 8'($urandom);
            rx_q.push_back(b);
            sum = sum + b;
        end
        b = CHECK_VALUE - sum;
        if (bad_sum)
            b = b ^ 8'($urandom_range(1, 255));
        rx_q.push_back(b);
    endfunction

    function automatic void push_noise(input int n);
        for (int i = 0; i < n; i++)
            rx_q.push_back(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
    endfunction

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (source_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_queue();
        while (rx_q.size() > 0)
            send_rx_byte(rx_q.pop_front());
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_beats != 0)
            @(negedge clk);
        // let a frame still in the parser finish before touching the register
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_device_id(input logic [7:0] id);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_id = id;
    endtask

    initial
    begin
        int         sel;
        int         seg_end;
        logic [7:0] len;
        logic [7:0] seg_id;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'd0;
        cfg_valid     = 1'b0;
        cfg_data      = 8'd0;
        source_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        hold_requests = 0;
        bytes_sent    = 0;
        cur_id        = DEVICE_ID_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames on the reset device ID
        push_frame(cur_id, 8'd0, 1'b1, 1'b0);
        push_frame(cur_id, 8'd1, 1'b1, 1'b0);
        rx_q.push_back(SYNC_BYTE);
        rx_q.push_back(8'h00);
        push_frame(cur_id, 8'd3, 1'b1, 1'b0);
        push_frame(8'h05, 8'd2, 1'b1, 1'b0);
        rx_q.push_back(SYNC_BYTE);
        rx_q.push_back(SYNC_BYTE);
        rx_q.push_back(SYNC_BYTE);
        push_frame(cur_id, 8'd2, 1'b1, 1'b0);
        push_frame(cur_id, 8'd2, 1'b1, 1'b1);
        push_frame(cur_id, 8'd31, 1'b1, 1'b0);
        push_frame(cur_id, 8'd32, 1'b1, 1'b0);
        push_frame(cur_id, 8'd40, 1'b1, 1'b0);
        send_queue();
        wait_idle();

        write_device_id(8'h00);
        push_frame(cur_id, 8'd0, 1'b1, 1'b0);
        push_frame(cur_id, 8'd4, 1'b1, 1'b0);
        push_frame(8'h01, 8'd1, 1'b1, 1'b0);
        send_queue();
        wait_idle();

        write_device_id(8'hFF);
        push_frame(cur_id, 8'd5, 1'b1, 1'b0);
        push_frame(cur_id, 8'd0, 1'b1, 1'b0);
        send_queue();
        wait_idle();

        // change the ID between the header and the ID byte
        rx_q.push_back(SYNC_BYTE);
        rx_q.push_back(SYNC_BYTE);
        send_queue();
        wait_idle();
        write_device_id(8'h5A);
        push_frame(cur_id, 8'd2, 1'b0, 1'b0);
        send_queue();
        wait_idle();

        // hold the sink so a frame stays in the store and input backs up
        hold_requests++;
        push_frame(cur_id, 8'd8, 1'b1, 1'b0);
        push_frame(cur_id, 8'd8, 1'b1, 1'b0);
        push_frame(cur_id, 8'd8, 1'b1, 1'b0);
        send_queue();
        wait_idle();

        seg_end = bytes_sent;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            case (seg)
                1:       seg_id = 8'h00;
                2:       seg_id = 8'hFF;
                default: seg_id = 8'($urandom);
            endcase
            write_device_id(seg_id);
            if (seg == SEGMENTS - 1)
            begin
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            seg_end += RANDOM_BYTES / SEGMENTS;
            while (bytes_sent < seg_end)
            begin
                sel = $urandom_range(0, 99);
                len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(9, 31))
                                                  : 8'($urandom_range(0, 8));
                if (sel < 62)
                    push_frame(cur_id, len, 1'b1, 1'b0);
                else if (sel < 72)
                    push_frame(cur_id, len, 1'b1, 1'b1);
                else if (sel < 80)
                    push_frame(cur_id + 8'($urandom_range(1, 255)), len, 1'b1, 1'b0);
                else if (sel < 88)
                    push_noise($urandom_range(1, 6));
                else if (sel < 93)
                begin
                    rx_q.push_back(SYNC_BYTE);
                    rx_q.push_back(8'($urandom_range(0, 254)));
                end
                else if (sel < 97)
                begin
                    // cut a frame short; the next bytes land in its body
                    rx_q.push_back(SYNC_BYTE);
                    rx_q.push_back(SYNC_BYTE);
                    rx_q.push_back(cur_id);
                    rx_q.push_back(8'($urandom_range(4, 12)));
                    push_noise($urandom_range(1, 2));
                end
                else
                begin
                    push_frame(cur_id, 8'($urandom_range(32, 40)), 1'b1, 1'b0);
                end
                send_queue();
            end
        end
        wait_idle();

        $display("Sent %0d bytes across device IDs 01, 00, FF, 5A and random values;",
                 bytes_sent);
        $display("%0d frames accepted, %0d result beats compared, one long sink hold-off.",
                 frames_accepted, beats_checked);
        if (fail_count == 0 && pending_beats == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            if (pending_beats != 0)
                $display("%0d expected results never arrived", pending_beats);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
